// ===== hdl/pid_dbc_pkg.sv =====
// Package of shared constants and types for the PID controller with deadband.
`timescale 1ns / 1ps

package pid_dbc_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int STEP_W    = 31;
    localparam int ADDR_W    = 5;

    // Time step used until a non-zero step arrives.
    localparam logic [STEP_W-1:0] DEFAULT_STEP = STEP_W'(6554);

    // Signed limits of a 32-bit word.
    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Shared divider: two restoring steps per cycle over an even dividend width.
    localparam int DIV_W     = DATA_W + FRAC_BITS + (FRAC_BITS % 2);
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Divisor of the slope filter: new = (4 * old + slope) / 5.
    localparam logic [STEP_W-1:0] FILT_DEN = STEP_W'(5);
    localparam int FILT_W = DATA_W + 3;

    // Shared multiplier and the widths of its scaled products.
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int QM_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W  = QM_W + 2;
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_SLOPE,
        ST_FILT,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_DEAD_WIDTH,
        REG_DRIVE_MIN,
        REG_DRIVE_MAX,
        REG_INTEG_MIN,
        REG_INTEG_MAX
    } t_reg_idx;

    // Operand selection of the shared multiplier, in the order of use.
    typedef enum logic [1:0] {
        MSEL_INTEG,
        MSEL_P,
        MSEL_I,
        MSEL_D
    } t_mul_sel;

    // Which quotient the shared divider is working on.
    typedef enum logic {
        PASS_SLOPE,
        PASS_FILT
    } t_div_pass;

endpackage

// ===== hdl/pid_deadband_controller.sv =====
// PID controller with deadband, filtered derivative and anti-windup clamps.
// Samples are taken one at a time: the input stalls from acceptance until the result
// is loaded into the output register. The shared divider does most of the work,
// running two restoring steps a cycle for the slope and again for the slope filter.
// Reset (synchronous, active low) clears the controller state, restores the
// register defaults and drops any pending result.
`timescale 1ns / 1ps

module pid_deadband_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [pid_dbc_pkg::DATA_W-1:0] i_setpoint,
    input  logic signed [pid_dbc_pkg::DATA_W-1:0] i_measured,
    input  logic        [pid_dbc_pkg::STEP_W-1:0] i_time_step,
    // Output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pid_dbc_pkg::DATA_W-1:0] o_drive,
    output logic                                  o_drive_clipped,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic        [pid_dbc_pkg::ADDR_W-1:0] paddr,
    input  logic        [pid_dbc_pkg::DATA_W-1:0] pwdata,
    output logic        [pid_dbc_pkg::DATA_W-1:0] prdata,
    output logic                                  pready
);

    localparam int DW  = pid_dbc_pkg::DATA_W;
    localparam int SW  = pid_dbc_pkg::STEP_W;
    localparam int VW  = pid_dbc_pkg::DIV_W;
    localparam int FB  = pid_dbc_pkg::FRAC_BITS;
    localparam int FW  = pid_dbc_pkg::FILT_W;
    localparam int MW  = pid_dbc_pkg::MUL_W;
    localparam int PW  = pid_dbc_pkg::PROD_W;
    localparam int QW  = pid_dbc_pkg::QM_W;
    localparam int UW  = pid_dbc_pkg::SUM_W;
    localparam int ADDR_W_HI = pid_dbc_pkg::ADDR_W - 1;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [SW+VW-1:0] div_step(input logic [SW-1:0] rem,
                                                  input logic [VW-1:0] quo,
                                                  input logic [SW-1:0] den);
        logic [SW:0] t;
        logic        qb;
        t  = {rem, quo[VW-1]};
        qb = 1'b0;
        if (t >= {1'b0, den}) begin
            t  = t - {1'b0, den};
            qb = 1'b1;
        end
        return {t[SW-1:0], quo[VW-2:0], qb};
    endfunction

    // Sequencer
    pid_dbc_pkg::t_state r_state, n_state;

    // Configuration registers
    logic signed [DW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic        [SW-1:0] r_dead_width;
    logic signed [DW-1:0] r_drive_min, r_drive_max, r_integ_min, r_integ_max;

    // Controller state carried between items
    logic signed [DW-1:0] r_last, r_fslope, r_integ;
    logic        [SW-1:0] r_held;

    // Current item
    logic signed [DW-1:0] r_sp, r_ms, r_err;

    // Shared divider
    logic [SW-1:0]                         r_rem, r_den;
    logic [VW-1:0]                         r_quo;
    logic                                  r_neg;
    logic [pid_dbc_pkg::DIV_CNT_W-1:0]     r_cnt;
    pid_dbc_pkg::t_div_pass                r_pass;

    // Shared multiplier and accumulator
    pid_dbc_pkg::t_mul_sel r_msel;
    logic signed [PW-1:0]  r_prod;
    logic signed [UW-1:0]  r_sum;

    // Output register
    logic                 r_out_valid;
    logic signed [DW-1:0] r_drive;
    logic                 r_clipped;

    // Handshake and control strobes
    logic w_busy, w_accept, w_out_free, w_out_load, w_cfg_wr;

    // Combinational datapath
    logic signed [DW:0]   w_diff;
    logic signed [DW-1:0] w_err_sat, w_err;
    logic signed [DW:0]   w_err_ext;
    logic        [DW:0]   w_err_mag;
    logic signed [DW:0]   w_edif;
    logic        [DW:0]   w_edif_mag;
    logic signed [DW-1:0] w_slope, w_filt;
    logic signed [FW-1:0] w_fx;
    logic        [FW-1:0] w_fx_mag;
    logic [SW+VW-1:0]     w_div1, w_div2;
    logic signed [MW-1:0] w_mul_a, w_mul_b;
    logic signed [PW-1:0] w_prod_adj;
    logic signed [QW-1:0] w_qm;
    logic signed [UW-1:0] w_int_sum, w_int_lo, w_int_new;
    logic signed [UW-1:0] w_drv_lo, w_drv_new;

    // Port handshakes
    assign w_cfg_wr   = psel & penable & pwrite;
    assign pready     = 1'b1;
    assign o_in_stall = w_busy | ~i_rst_n;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;
    assign o_drive_clipped = r_clipped;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pid_dbc_pkg::ST_IDLE: begin
                if (w_accept) n_state = pid_dbc_pkg::ST_ERR;
            end
            pid_dbc_pkg::ST_ERR:   n_state = pid_dbc_pkg::ST_DIV;
            pid_dbc_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = (r_pass == pid_dbc_pkg::PASS_SLOPE) ?
                              pid_dbc_pkg::ST_SLOPE : pid_dbc_pkg::ST_FILT;
                end
            end
            pid_dbc_pkg::ST_SLOPE: n_state = pid_dbc_pkg::ST_DIV;
            pid_dbc_pkg::ST_FILT:  n_state = pid_dbc_pkg::ST_MUL;
            pid_dbc_pkg::ST_MUL:   n_state = pid_dbc_pkg::ST_ACC;
            pid_dbc_pkg::ST_ACC: begin
                n_state = (r_msel == pid_dbc_pkg::MSEL_D) ?
                          pid_dbc_pkg::ST_DONE : pid_dbc_pkg::ST_MUL;
            end
            pid_dbc_pkg::ST_DONE: begin
                if (w_out_free) n_state = pid_dbc_pkg::ST_IDLE;
            end
            default: n_state = pid_dbc_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        w_busy     = 1'b1;
        w_out_load = 1'b0;
        case (r_state)
            pid_dbc_pkg::ST_IDLE: w_busy = 1'b0;
            pid_dbc_pkg::ST_DONE: w_out_load = w_out_free;
            default: begin
                w_busy     = 1'b1;
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pid_dbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Register read-back.
    always_comb begin
        case (pid_dbc_pkg::t_reg_idx'(paddr[ADDR_W_HI:2]))
            pid_dbc_pkg::REG_GAIN_P:     prdata = r_gain_p;
            pid_dbc_pkg::REG_GAIN_I:     prdata = r_gain_i;
            pid_dbc_pkg::REG_GAIN_D:     prdata = r_gain_d;
            pid_dbc_pkg::REG_DEAD_WIDTH: prdata = DW'(r_dead_width);
            pid_dbc_pkg::REG_DRIVE_MIN:  prdata = r_drive_min;
            pid_dbc_pkg::REG_DRIVE_MAX:  prdata = r_drive_max;
            pid_dbc_pkg::REG_INTEG_MIN:  prdata = r_integ_min;
            pid_dbc_pkg::REG_INTEG_MAX:  prdata = r_integ_max;
            default:                     prdata = '0;
        endcase
    end

    // Error: saturated difference, then forced to zero inside the deadband.
    always_comb begin
        w_diff = {r_sp[DW-1], r_sp} - {r_ms[DW-1], r_ms};
        if (w_diff[DW] != w_diff[DW-1]) begin
            w_err_sat = w_diff[DW] ? pid_dbc_pkg::S32_MIN : pid_dbc_pkg::S32_MAX;
        end else begin
            w_err_sat = w_diff[DW-1:0];
        end
        w_err_ext = {w_err_sat[DW-1], w_err_sat};
        w_err_mag = w_err_ext[DW] ? (DW+1)'(-w_err_ext) : (DW+1)'(w_err_ext);
        if ({w_err_mag, 1'b0} <= (DW+2)'(r_dead_width)) begin
            w_err = '0;
        end else begin
            w_err = w_err_sat;
        end
        // Change of error since the last item, as sign and magnitude.
        w_edif     = {w_err[DW-1], w_err} - {r_last[DW-1], r_last};
        w_edif_mag = w_edif[DW] ? (DW+1)'(-w_edif) : (DW+1)'(w_edif);
    end

    // Slope from the first quotient, saturated, and the filter dividend.
    always_comb begin
        if (r_neg) begin
            if (r_quo > VW'({1'b1, {(DW-1){1'b0}}})) w_slope = pid_dbc_pkg::S32_MIN;
            else                                     w_slope = -$signed(r_quo[DW-1:0]);
        end else begin
            if (r_quo > VW'({1'b0, {(DW-1){1'b1}}})) w_slope = pid_dbc_pkg::S32_MAX;
            else                                     w_slope = $signed(r_quo[DW-1:0]);
        end
        w_fx     = (FW'(r_fslope) <<< 2) + FW'(w_slope);
        w_fx_mag = w_fx[FW-1] ? FW'(-w_fx) : FW'(w_fx);
        // The filtered slope always fits in 32 bits.
        w_filt   = r_neg ? -$signed(r_quo[DW-1:0]) : $signed(r_quo[DW-1:0]);
    end

    // Two divider steps per cycle.
    always_comb begin
        w_div1 = div_step(r_rem, r_quo, r_den);
        w_div2 = div_step(w_div1[SW+VW-1:VW], w_div1[VW-1:0], r_den);
    end

    // Multiplier operand selection and the scaled, zero-truncated product.
    always_comb begin
        case (r_msel)
            pid_dbc_pkg::MSEL_INTEG: begin
                w_mul_a = MW'(r_err);
                w_mul_b = MW'(r_held);
            end
            pid_dbc_pkg::MSEL_P: begin
                w_mul_a = MW'(r_gain_p);
                w_mul_b = MW'(r_err);
            end
            pid_dbc_pkg::MSEL_I: begin
                w_mul_a = MW'(r_gain_i);
                w_mul_b = MW'(r_integ);
            end
            pid_dbc_pkg::MSEL_D: begin
                w_mul_a = MW'(r_gain_d);
                w_mul_b = MW'(r_fslope);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod_adj = r_prod[PW-1] ? (r_prod + $signed(pid_dbc_pkg::ROUND_BIAS)) : r_prod;
        w_qm       = QW'(w_prod_adj >>> FB);
    end

    // Integral update with its clamp (lower bound first), and the drive clamp.
    always_comb begin
        w_int_sum = UW'(r_integ) + UW'(w_qm);
        w_int_lo  = (w_int_sum < UW'(r_integ_min)) ? UW'(r_integ_min) : w_int_sum;
        w_int_new = (w_int_lo > UW'(r_integ_max)) ? UW'(r_integ_max) : w_int_lo;
        w_drv_lo  = (r_sum < UW'(r_drive_min)) ? UW'(r_drive_min) : r_sum;
        w_drv_new = (w_drv_lo > UW'(r_drive_max)) ? UW'(r_drive_max) : w_drv_lo;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_dead_width <= '0;
            r_drive_min  <= pid_dbc_pkg::S32_MIN;
            r_drive_max  <= pid_dbc_pkg::S32_MAX;
            r_integ_min  <= pid_dbc_pkg::S32_MIN;
            r_integ_max  <= pid_dbc_pkg::S32_MAX;
        end else if (w_cfg_wr) begin
            case (pid_dbc_pkg::t_reg_idx'(paddr[ADDR_W_HI:2]))
                pid_dbc_pkg::REG_GAIN_P:     r_gain_p     <= pwdata;
                pid_dbc_pkg::REG_GAIN_I:     r_gain_i     <= pwdata;
                pid_dbc_pkg::REG_GAIN_D:     r_gain_d     <= pwdata;
                pid_dbc_pkg::REG_DEAD_WIDTH: r_dead_width <= pwdata[SW-1:0];
                pid_dbc_pkg::REG_DRIVE_MIN:  r_drive_min  <= pwdata;
                pid_dbc_pkg::REG_DRIVE_MAX:  r_drive_max  <= pwdata;
                pid_dbc_pkg::REG_INTEG_MIN:  r_integ_min  <= pwdata;
                pid_dbc_pkg::REG_INTEG_MAX:  r_integ_max  <= pwdata;
                default: ;
            endcase
        end
    end

    // Controller state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_fslope    <= '0;
            r_integ     <= '0;
            r_held      <= pid_dbc_pkg::DEFAULT_STEP;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && (i_time_step != '0)) begin
                r_held <= i_time_step;
            end
            if (r_state == pid_dbc_pkg::ST_ERR) begin
                r_last <= w_err;
            end
            if (r_state == pid_dbc_pkg::ST_FILT) begin
                r_fslope <= w_filt;
            end
            // The integral holds while the error is zero.
            if ((r_state == pid_dbc_pkg::ST_ACC) && (r_msel == pid_dbc_pkg::MSEL_INTEG)
                && (r_err != '0)) begin
                r_integ <= DW'(w_int_new);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sp <= i_setpoint;
            r_ms <= i_measured;
        end
        if (w_out_load) begin
            r_drive   <= DW'(w_drv_new);
            r_clipped <= (w_drv_new != r_sum);
        end
        case (r_state)
            // Load the divider with |change of error| scaled by one unit over the step.
            pid_dbc_pkg::ST_ERR: begin
                r_err  <= w_err;
                r_rem  <= '0;
                r_quo  <= VW'({w_edif_mag[DW-1:0], {FB{1'b0}}});
                r_den  <= r_held;
                r_neg  <= w_edif[DW];
                r_cnt  <= pid_dbc_pkg::DIV_CNT_W'(pid_dbc_pkg::DIV_STEPS - 1);
                r_pass <= pid_dbc_pkg::PASS_SLOPE;
            end
            pid_dbc_pkg::ST_DIV: begin
                r_rem <= w_div2[SW+VW-1:VW];
                r_quo <= w_div2[VW-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
            // Load the divider again for the slope filter.
            pid_dbc_pkg::ST_SLOPE: begin
                r_rem  <= '0;
                r_quo  <= VW'(w_fx_mag);
                r_den  <= pid_dbc_pkg::FILT_DEN;
                r_neg  <= w_fx[FW-1];
                r_cnt  <= pid_dbc_pkg::DIV_CNT_W'(pid_dbc_pkg::DIV_STEPS - 1);
                r_pass <= pid_dbc_pkg::PASS_FILT;
            end
            pid_dbc_pkg::ST_FILT: begin
                r_msel <= pid_dbc_pkg::MSEL_INTEG;
            end
            pid_dbc_pkg::ST_MUL: begin
                r_prod <= w_mul_a * w_mul_b;
            end
            // Sum the three gain terms; the first product feeds the integral.
            pid_dbc_pkg::ST_ACC: begin
                case (r_msel)
                    pid_dbc_pkg::MSEL_INTEG: ;
                    pid_dbc_pkg::MSEL_P:     r_sum <= UW'(w_qm);
                    default:                 r_sum <= r_sum + UW'(w_qm);
                endcase
                r_msel <= pid_dbc_pkg::t_mul_sel'(r_msel + 1'b1);
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/pid_dbc_checker.sv =====
// Port-level checker for the PID controller, bound to the top level.
`timescale 1ns / 1ps

module pid_dbc_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [pid_dbc_pkg::DATA_W-1:0] o_drive,
    input logic                                  o_drive_clipped
);

    // Reset leaves no result pending, and the input opens once reset is released.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && (!i_rst_n || !o_in_stall)))
        else $error("state after reset is not idle");

    // Once a transaction is accepted the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again while an item is in work");

    // A new result only appears at the end of work on an item.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_drive) && $stable(o_drive_clipped)))
        else $error("stalled result changed");

endmodule

bind pid_deadband_controller pid_dbc_checker u_pid_dbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_drive         (o_drive),
    .o_drive_clipped (o_drive_clipped)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the PID controller with deadband and anti-windup clamps.
`timescale 1ns / 1ps

module testbench;

    // Field widths and fixed-point format of the block.
    localparam int FRAC_BITS = pid_dbc_pkg::FRAC_BITS;
    localparam int DATA_W    = pid_dbc_pkg::DATA_W;
    localparam int STEP_W    = pid_dbc_pkg::STEP_W;
    localparam int ADDR_W    = pid_dbc_pkg::ADDR_W;

    // Run limits: cycle ceiling, long output hold-off, and the cap on printed mismatches.
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned MAX_PRINTED  = 40;
    localparam int unsigned PHASE_ITEMS  = 144;

    // Fixed-point helpers for the predictor.
    localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
    localparam longint S32_HI = (longint'(1) << 31) - 1;
    localparam longint S32_LO = -(longint'(1) << 31);

    // One control sample offered on the input channel.
    typedef struct packed {
        logic [DATA_W-1:0] setpoint;
        logic [DATA_W-1:0] measured;
        logic [STEP_W-1:0] time_step;
    } t_ctrl_item;

    // One drive result expected on the output channel.
    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              clipped;
    } t_drive_result;

    typedef logic [DATA_W-1:0] t_reg_file [8];

    // Clock, reset and block ports.
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_setpoint = '0;
    logic signed [DATA_W-1:0] i_measured = '0;
    logic        [STEP_W-1:0] i_time_step = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_drive;
    logic                     o_drive_clipped;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic        [ADDR_W-1:0] paddr = '0;
    logic        [DATA_W-1:0] pwdata = '0;
    logic        [DATA_W-1:0] prdata;
    logic                     pready;

    // Pending control samples and the drive results they should produce.
    t_ctrl_item    control_q[$];
    t_drive_result drive_q[$];
    t_ctrl_item    next_sample;
    t_drive_result drive_head;

    // Copy of the registers as written, and the controller state tracked alongside the block.
    logic [DATA_W-1:0] reg_shadow [8];
    longint            prev_error = 0;
    longint            slope_filt = 0;
    longint            integ_acc = 0;
    longint            step_held = longint'(pid_dbc_pkg::DEFAULT_STEP);

    // Idling controls for the current phase.
    int unsigned send_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    bit          hold_request = 1'b0;
    bit          long_hold = 1'b0;
    bit          in_taken = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    pid_deadband_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_setpoint      (i_setpoint),
        .i_measured      (i_measured),
        .i_time_step     (i_time_step),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_drive         (o_drive),
        .o_drive_clipped (o_drive_clipped),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock generation.
    always #1 i_clk = ~i_clk;

    // Mismatch reporting: one line per failure, the printout capped.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic longint limit_to(input longint x, input longint lo, input longint hi);
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return x;
    endfunction

    // Fixed-point product, truncated toward zero.
    function automatic longint scale_q(input longint a, input longint b);
        return (a * b) / ONE_Q;
    endfunction

    function automatic longint reg_signed(input pid_dbc_pkg::t_reg_idx idx);
        return longint'($signed(reg_shadow[idx]));
    endfunction

    // Works out the drive result of one accepted sample and advances the tracked state.
    function automatic void predict_drive(input logic [DATA_W-1:0] sp_bits,
                                          input logic [DATA_W-1:0] ms_bits,
                                          input logic [STEP_W-1:0] ts_bits);
        longint        err;
        longint        mag;
        longint        slope;
        longint        sum;
        longint        drv;
        t_drive_result res;
        if (ts_bits != '0) step_held = longint'(ts_bits);
        err = limit_to(longint'($signed(sp_bits)) - longint'($signed(ms_bits)), S32_LO, S32_HI);
        mag = (err < 0) ? -err : err;
        // Inside the deadband the error counts as zero.
        if (2 * mag <= longint'(reg_shadow[pid_dbc_pkg::REG_DEAD_WIDTH])) err = 0;
        slope = limit_to(((err - prev_error) * ONE_Q) / step_held, S32_LO, S32_HI);
        slope_filt = (4 * slope_filt + slope) / 5;
        // The integral only moves while there is an error to act on.
        if (err != 0) begin
            integ_acc = limit_to(integ_acc + scale_q(err, step_held),
                                 reg_signed(pid_dbc_pkg::REG_INTEG_MIN),
                                 reg_signed(pid_dbc_pkg::REG_INTEG_MAX));
            integ_acc = limit_to(integ_acc, S32_LO, S32_HI);
        end
        sum = scale_q(reg_signed(pid_dbc_pkg::REG_GAIN_P), err)
            + scale_q(reg_signed(pid_dbc_pkg::REG_GAIN_I), integ_acc)
            + scale_q(reg_signed(pid_dbc_pkg::REG_GAIN_D), slope_filt);
        drv = limit_to(sum, reg_signed(pid_dbc_pkg::REG_DRIVE_MIN),
                       reg_signed(pid_dbc_pkg::REG_DRIVE_MAX));
        prev_error = err;
        res.drive = drv[DATA_W-1:0];
        res.clipped = (drv != sum);
        drive_q.push_back(res);
    endfunction

    // Register write over the configuration port: setup cycle, then access cycle.
    task automatic bus_write(input pid_dbc_pkg::t_reg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        reg_shadow[idx] = (idx == pid_dbc_pkg::REG_DEAD_WIDTH) ?
                          {1'b0, value[STEP_W-1:0]} : value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Register read over the configuration port, checked against the written value.
    task automatic bus_readback(input pid_dbc_pkg::t_reg_idx idx);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== reg_shadow[idx]) begin
            report_mismatch($sformatf("register %s read %h, written %h",
                                      idx.name(), prdata, reg_shadow[idx]));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input t_reg_file regs);
        for (int i = 0; i < 8; i++) bus_write(pid_dbc_pkg::t_reg_idx'(i), regs[i]);
        for (int i = 0; i < 8; i++) bus_readback(pid_dbc_pkg::t_reg_idx'(i));
    endtask

    // Waits until every queued sample has gone in and every result has come out.
    task automatic settle();
        while (!(control_q.size() == 0 && !i_in_valid && drive_q.size() == 0)) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
    endtask

    task automatic queue_item(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] ms,
                              input logic [STEP_W-1:0] ts);
        t_ctrl_item it;
        it.setpoint = sp;
        it.measured = ms;
        it.time_step = ts;
        control_q.push_back(it);
    endtask

    // Random samples: mostly small errors around a moderate setpoint, some full range.
    task automatic queue_random(input int unsigned count);
        logic [DATA_W-1:0] sp;
        logic [DATA_W-1:0] ms;
        logic [STEP_W-1:0] ts;
        int                delta;
        repeat (count) begin
            if ($urandom_range(3) == 0) begin
                sp = $urandom;
                ms = $urandom;
            end else begin
                sp = DATA_W'(int'($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
                delta = ($urandom_range(7) == 0) ? 0
                      : int'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
                ms = sp - DATA_W'(delta);
            end
            case ($urandom_range(9))
                0, 1: ts = '0;
                7: ts = STEP_W'($urandom_range(16, 1));
                8, 9: ts = STEP_W'($urandom);
                default: ts = STEP_W'($urandom_range(32'h0002_0000, 1));
            endcase
            queue_item(sp, ms, ts);
        end
    endtask

    function automatic logic [DATA_W-1:0] random_gain();
        if ($urandom_range(1) == 0) return $urandom;
        return DATA_W'(int'($urandom_range(32'h0006_0000)) - 32'sh0003_0000);
    endfunction

    // Clamp bounds, now and then deliberately inverted.
    function automatic void random_bounds(output logic [DATA_W-1:0] lo,
                                          output logic [DATA_W-1:0] hi);
        int a;
        int b;
        a = -int'($urandom_range(32'h0040_0000));
        b = int'($urandom_range(32'h0040_0000));
        if ($urandom_range(3) == 0) begin
            lo = DATA_W'(b);
            hi = DATA_W'(a);
        end else begin
            lo = DATA_W'(a);
            hi = DATA_W'(b);
        end
    endfunction

    function automatic t_reg_file random_settings();
        t_reg_file regs;
        regs[pid_dbc_pkg::REG_GAIN_P] = random_gain();
        regs[pid_dbc_pkg::REG_GAIN_I] = random_gain();
        regs[pid_dbc_pkg::REG_GAIN_D] = random_gain();
        regs[pid_dbc_pkg::REG_DEAD_WIDTH] = $urandom_range(32'h0001_0000);
        random_bounds(regs[pid_dbc_pkg::REG_DRIVE_MIN], regs[pid_dbc_pkg::REG_DRIVE_MAX]);
        random_bounds(regs[pid_dbc_pkg::REG_INTEG_MIN], regs[pid_dbc_pkg::REG_INTEG_MAX]);
        return regs;
    endfunction

    // Input driver: presents the next sample at the falling edge once the last one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (control_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_sample = control_q.pop_front();
                i_setpoint <= next_sample.setpoint;
                i_measured <= next_sample.measured;
                i_time_step <= next_sample.time_step;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Input acceptance: each input transaction is predicted as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_drive(i_setpoint, i_measured, i_time_step);
            in_taken = 1'b1;
        end
    end

    // Output stall driver, with the long hold-off taking priority.
    always @(negedge i_clk) begin
        i_out_stall <= long_hold || ($urandom_range(99) < out_stall_pct);
    end

    // Long receiver hold-off, counted in cycles, so that the block backs up onto its input.
    initial begin
        wait (hold_request);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Output monitor: each output transaction is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result drive=%0d clipped=%0b",
                                          o_drive, o_drive_clipped));
            end else begin
                drive_head = drive_q.pop_front();
                if (o_drive !== drive_head.drive) begin
                    report_mismatch($sformatf("drive %0d, expected %0d",
                                              o_drive, $signed(drive_head.drive)));
                end
                if (o_drive_clipped !== drive_head.clipped) begin
                    report_mismatch($sformatf("drive_clipped %0b, expected %0b",
                                              o_drive_clipped, drive_head.clipped));
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus sequence: reset, directed samples, then random phases under several settings.
    initial begin
        t_reg_file regs;
        reg_shadow[pid_dbc_pkg::REG_GAIN_P] = '0;
        reg_shadow[pid_dbc_pkg::REG_GAIN_I] = '0;
        reg_shadow[pid_dbc_pkg::REG_GAIN_D] = '0;
        reg_shadow[pid_dbc_pkg::REG_DEAD_WIDTH] = '0;
        reg_shadow[pid_dbc_pkg::REG_DRIVE_MIN] = pid_dbc_pkg::S32_MIN;
        reg_shadow[pid_dbc_pkg::REG_DRIVE_MAX] = pid_dbc_pkg::S32_MAX;
        reg_shadow[pid_dbc_pkg::REG_INTEG_MIN] = pid_dbc_pkg::S32_MIN;
        reg_shadow[pid_dbc_pkg::REG_INTEG_MAX] = pid_dbc_pkg::S32_MAX;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Typical tuning: kp 1.0, ki 0.5, kd 0.25, deadband 0.125, drive +-100, integral +-50.
        regs = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000,
                 32'hFF9C_0000, 32'h0064_0000, 32'hFFCE_0000, 32'h0032_0000};
        apply_settings(regs);
        set_idling(0, 0);
        // Zero step straight after reset falls back to the default step.
        queue_item(32'h0000_0000, 32'h0000_0000, 31'h0);
        // Errors on and just beyond the deadband edge, both signs.
        queue_item(32'h0000_1000, 32'h0000_0000, 31'h0001_0000);
        queue_item(32'h0000_1001, 32'h0000_0000, 31'h0001_0000);
        queue_item(32'h0000_0000, 32'h0000_1000, 31'h0);
        queue_item(32'h0000_0000, 32'h0000_1001, 31'h0000_8000);
        // Saturating error in both directions, smallest step then reused.
        queue_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h1);
        queue_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
        // Largest step, then the integral driven into each clamp.
        queue_item(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
        queue_item(32'h7FFF_FFFF, 32'h0000_0000, 31'h0);
        queue_item(32'h8000_0000, 32'h0000_0000, 31'h0001_0000);
        // Drive clipped high, then low.
        queue_item(32'h0064_0000, 32'hFF9C_0000, 31'h0001_0000);
        queue_item(32'hFF9C_0000, 32'h0064_0000, 31'h0001_0000);
        // Zero error holds the integral.
        queue_item(32'h0003_0000, 32'h0003_0000, 31'h0001_0000);
        queue_item(32'h0002_0000, 32'h0001_0000, 31'h0000_4000);
        queue_item(32'h0001_0000, 32'h0002_0000, 31'h0);
        queue_item(32'hFFFF_FFFF, 32'h0000_0000, 31'h5555_5555);
        queue_item(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA);
        settle();
        queue_random(PHASE_ITEMS);
        settle();

        // Largest positive gains, no deadband, full clamps; sender mostly idle.
        regs = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        apply_settings(regs);
        set_idling(75, 0);
        queue_random(PHASE_ITEMS);
        settle();

        // Most negative gains and the widest deadband; receiver mostly stalling.
        regs = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        apply_settings(regs);
        set_idling(0, 75);
        queue_random(PHASE_ITEMS);
        settle();

        // Inverted drive and integral bounds; both sides idling.
        regs = '{32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_1000,
                 32'h0010_0000, 32'hFFF0_0000, 32'h0005_0000, 32'hFFFB_0000};
        apply_settings(regs);
        set_idling(32, 32);
        queue_random(PHASE_ITEMS);
        settle();

        // Narrow drive range and a pinned integral, with a long receiver hold-off.
        regs = '{32'h0000_C000, 32'h0000_4000, 32'h0001_8000, 32'h0000_0800,
                 32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_8000};
        apply_settings(regs);
        set_idling(0, 0);
        hold_request = 1'b1;
        queue_random(PHASE_ITEMS);
        settle();

        // Random tunings, each under one of the idling patterns used above.
        apply_settings(random_settings());
        set_idling(32, 32);
        queue_random(PHASE_ITEMS);
        settle();
        apply_settings(random_settings());
        set_idling(75, 0);
        queue_random(PHASE_ITEMS);
        settle();
        apply_settings(random_settings());
        set_idling(0, 75);
        queue_random(PHASE_ITEMS);
        settle();

        // Let any stray result show before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
